[rtl/edd_pkg.sv]
package edd_pkg;

    // String capacity and derived widths
    localparam int MAX_LEN = 64;
    localparam int LEN_W   = $clog2(MAX_LEN + 1);
    localparam int ADDR_W  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int COST_W  = LEN_W + 1;
    localparam int CHAR_W  = 16;
    localparam int KIND_W  = 2;
    localparam int DIST_W  = 7;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TEXT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMIT = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [CHAR_W-1:0] char_code;
    } edd_in_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              overflow;
    } edd_out_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROW,
        ST_DRAIN,
        ST_EMIT
    } edd_state_t;

    // Controller to datapath
    typedef struct packed {
        logic              pat_wr;
        logic              ovf_set;
        logic              txt_start;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              cmp_en;
        logic              res_load;
    } edd_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic [LEN_W-1:0] pat_len;
        logic [LEN_W-1:0] text_len;
    } edd_stat_t;

endpackage

[rtl/edd_ram.sv]
module edd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port, one registered read port; read data holds when idle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/edd_ctrl.sv]
module edd_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  logic [edd_pkg::KIND_W-1:0]   item_kind,
    output logic                         result_valid,
    input  logic                         result_ready,
    input  edd_pkg::edd_stat_t           stat,
    output edd_pkg::edd_cmd_t            cmd
);

    edd_pkg::edd_state_t           state_reg, state_next;
    logic [edd_pkg::ADDR_W-1:0]    cnt_reg, cnt_next;
    logic                          pipe_vld_reg, pipe_vld_next;
    logic                          out_vld_reg, out_vld_next;
    logic                          accept;
    logic                          out_busy;
    logic                          pat_full;
    logic                          text_full;
    logic                          row_last;

    assign item_ready   = (state_reg == edd_pkg::ST_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = out_vld_reg;
    assign out_busy     = out_vld_reg && !result_ready;
    assign pat_full     = (stat.pat_len == edd_pkg::LEN_W'(edd_pkg::MAX_LEN));
    assign text_full    = (stat.text_len == edd_pkg::LEN_W'(edd_pkg::MAX_LEN));
    assign row_last     = (edd_pkg::LEN_W'(cnt_reg) == stat.pat_len - 1'b1);

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= edd_pkg::ST_IDLE;
            cnt_reg      <= '0;
            pipe_vld_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            pipe_vld_reg <= pipe_vld_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        cmd.cmp_en   = pipe_vld_reg;
        cmd.rd_addr  = cnt_reg;
        case (state_reg)
            edd_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (item_kind)
                        edd_pkg::KIND_LOAD:
                        begin
                            // first-string chars after the second string began are ignored
                            if (stat.text_len == '0)
                            begin
                                if (pat_full)
                                begin
                                    cmd.ovf_set = 1'b1;
                                end
                                else
                                begin
                                    cmd.pat_wr = 1'b1;
                                end
                            end
                        end
                        edd_pkg::KIND_TEXT:
                        begin
                            if (text_full)
                            begin
                                cmd.ovf_set = 1'b1;
                            end
                            else
                            begin
                                cmd.txt_start = 1'b1;
                                if (stat.pat_len != '0)
                                begin
                                    cnt_next   = '0;
                                    state_next = edd_pkg::ST_ROW;
                                end
                            end
                        end
                        edd_pkg::KIND_EMIT:
                        begin
                            cmd.rd_en   = 1'b1;
                            cmd.rd_addr = edd_pkg::ADDR_W'(stat.pat_len - 1'b1);
                            state_next  = edd_pkg::ST_EMIT;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            edd_pkg::ST_ROW:
            begin
                cmd.rd_en = 1'b1;
                if (row_last)
                begin
                    state_next = edd_pkg::ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            edd_pkg::ST_DRAIN:
            begin
                state_next = edd_pkg::ST_IDLE;
            end
            edd_pkg::ST_EMIT:
            begin
                if (!out_busy)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = edd_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = edd_pkg::ST_IDLE;
            end
        endcase
        pipe_vld_next = (state_reg == edd_pkg::ST_ROW);
        if (cmd.res_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_vld_next = 1'b0;
        end
        else
        begin
            out_vld_next = out_vld_reg;
        end
    end

    // Cell updates happen only while a row sweep is running
    a_cmp_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp_en |-> (state_reg == edd_pkg::ST_ROW || state_reg == edd_pkg::ST_DRAIN))
        else $error("cell update outside row sweep");

    // Sweep index stays inside the loaded first string
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == edd_pkg::ST_ROW) |-> (edd_pkg::LEN_W'(cnt_reg) < stat.pat_len))
        else $error("sweep index beyond first string");

    // A loaded result is offered in the next cycle
    a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |=> result_valid)
        else $error("loaded result not offered");

    // Drain is always followed by idle
    a_drain_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == edd_pkg::ST_DRAIN) |=> (state_reg == edd_pkg::ST_IDLE))
        else $error("drain did not return to idle");

endmodule

[rtl/edd_datapath.sv]
module edd_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  edd_pkg::edd_in_t    item,
    input  edd_pkg::edd_cmd_t   cmd,
    output edd_pkg::edd_stat_t  stat,
    output edd_pkg::edd_out_t   result
);

    logic [edd_pkg::LEN_W-1:0]  pat_len_reg;
    logic [edd_pkg::LEN_W-1:0]  text_len_reg;
    logic                       ovf_reg;
    logic                       first_reg;
    logic [edd_pkg::CHAR_W-1:0] ch_reg;
    logic [edd_pkg::COST_W-1:0] diag_reg;
    logic [edd_pkg::COST_W-1:0] left_reg;
    logic [edd_pkg::ADDR_W-1:0] addr_d_reg;
    edd_pkg::edd_out_t          result_reg;

    logic [edd_pkg::CHAR_W-1:0] pat_q;
    logic [edd_pkg::LEN_W-1:0]  cost_q;
    logic [edd_pkg::COST_W-1:0] up;
    logic [edd_pkg::COST_W-1:0] cell_cost;
    logic [edd_pkg::LEN_W-1:0]  final_cost;
    logic                       sub;

    function automatic logic [edd_pkg::COST_W-1:0] min3(
        input logic [edd_pkg::COST_W-1:0] a,
        input logic [edd_pkg::COST_W-1:0] b,
        input logic [edd_pkg::COST_W-1:0] c
    );
        logic [edd_pkg::COST_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    // First string store
    edd_ram #(
        .WIDTH (edd_pkg::CHAR_W),
        .DEPTH (edd_pkg::MAX_LEN)
    ) u_pat_ram (
        .clk     (clk),
        .wr_en   (cmd.pat_wr),
        .wr_addr (edd_pkg::ADDR_W'(pat_len_reg)),
        .wr_data (item.char_code),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (pat_q)
    );

    // Cost row cells 1..MAX_LEN at address cell-1; cell 0 always equals text_len
    edd_ram #(
        .WIDTH (edd_pkg::LEN_W),
        .DEPTH (edd_pkg::MAX_LEN)
    ) u_cost_ram (
        .clk     (clk),
        .wr_en   (cmd.cmp_en),
        .wr_addr (addr_d_reg),
        .wr_data (edd_pkg::LEN_W'(cell_cost)),
        .rd_en   (cmd.rd_en),
        .rd_addr (cmd.rd_addr),
        .rd_data (cost_q)
    );

    // One cell: row is unwritten on the first text char, so it reads as its index
    assign up        = first_reg ? (edd_pkg::COST_W'(addr_d_reg) + 1'b1)
                                 : edd_pkg::COST_W'(cost_q);
    assign sub       = (pat_q != ch_reg);
    assign cell_cost = min3(left_reg + 1'b1, up + 1'b1, diag_reg + edd_pkg::COST_W'(sub));

    // Final distance, empty strings handled without the row
    always_comb
    begin
        if (pat_len_reg == '0)
        begin
            final_cost = text_len_reg;
        end
        else if (text_len_reg == '0)
        begin
            final_cost = pat_len_reg;
        end
        else
        begin
            final_cost = cost_q;
        end
    end

    // Pair control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_len_reg  <= '0;
            text_len_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            pat_len_reg  <= '0;
            text_len_reg <= '0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            if (cmd.pat_wr)
            begin
                pat_len_reg <= pat_len_reg + 1'b1;
            end
            if (cmd.txt_start)
            begin
                text_len_reg <= text_len_reg + 1'b1;
            end
            if (cmd.ovf_set)
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    // Sweep payload
    always_ff @(posedge clk)
    begin
        addr_d_reg <= cmd.rd_addr;
        if (cmd.txt_start)
        begin
            first_reg <= (text_len_reg == '0);
            ch_reg    <= item.char_code;
            diag_reg  <= edd_pkg::COST_W'(text_len_reg);
            left_reg  <= edd_pkg::COST_W'(text_len_reg) + 1'b1;
        end
        else if (cmd.cmp_en)
        begin
            diag_reg <= up;
            left_reg <= cell_cost;
        end
        if (cmd.res_load)
        begin
            result_reg.distance <= edd_pkg::DIST_W'(final_cost);
            result_reg.overflow <= ovf_reg;
        end
    end

    assign stat.pat_len  = pat_len_reg;
    assign stat.text_len = text_len_reg;
    assign result        = result_reg;

endmodule

[rtl/edit_distance_engine_top.sv]
// A first-string beat is stored, or flagged as overflow, without leaving idle; a second-string
// beat runs the row sweep, one cell per cycle across the first string, then a drain state,
// unless the first string is empty or the second is full. An emit beat enters the EMIT state,
// waits there while an earlier result is held, then loads the result; result_valid is registered.
// Throughput: one beat at a time. Reset (rst_n, async low) clears lengths, flag, controller
// state and result valid; the cost row needs no clearing pass, first-string memory undefined.
module edit_distance_engine_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  edd_pkg::edd_in_t  item,
    output logic              result_valid,
    input  logic              result_ready,
    output edd_pkg::edd_out_t result
);

    edd_pkg::edd_cmd_t  cmd;
    edd_pkg::edd_stat_t stat;

    edd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_kind    (item.kind),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    edd_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
